// ===== src/radial_profile_histogram_top_assert.svh =====
`ifndef RADIAL_PROFILE_HISTOGRAM_TOP_ASSERT_SVH
`define RADIAL_PROFILE_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RPH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radial profile check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RPH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radial profile check failed");

`endif

// ===== src/rph_pkg.sv =====
`timescale 1ns / 1ps

package rph_pkg;

    localparam int NUM_BINS  = 256;
    localparam int GRID_SIZE = 1024;
    localparam int BIN_AW    = $clog2(NUM_BINS);
    localparam int AXES      = 3;

    // field widths
    localparam int GRID_W     = 10;
    localparam int SAMPLE_W   = 16;
    localparam int SEL_W      = 8;
    localparam int BIN_W      = 48;
    localparam int COORD_W    = 24;
    localparam int SPACING_W  = 16;
    localparam int IBW_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // datapath widths
    localparam int POS_W      = GRID_W + SPACING_W;
    localparam int AXSQ_W     = 2 * POS_W;
    localparam int D2_W       = AXSQ_W + 2;
    localparam int LIM_W      = 2 * COORD_W;
    localparam int ROOT_W     = COORD_W;
    localparam int ROOT_CNT_W = $clog2(ROOT_W);
    localparam int REM_W      = ROOT_W + 2;
    localparam int PROD_W     = ROOT_W + IBW_W;
    localparam int ROUND_SH   = 20;
    localparam int IDX_W      = PROD_W + 1 - ROUND_SH;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int VOL2_W     = 2 * SPACING_W;
    localparam int VOL_W      = 3 * SPACING_W;
    localparam int VOL_HALF   = VOL_W / 2;
    localparam int PART_W     = SQ_W + VOL_HALF;
    localparam int MASS_SH    = 12;

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ROUND_SH - 1);

    // operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Z  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WIDTH = 4'd7;

    // register reset values
    localparam logic [SPACING_W-1:0] SPACING_RST = 16'd4096;
    localparam logic [COORD_W-1:0]   RADIUS_RST  = 24'hFFFFFF;
    localparam logic [IBW_W-1:0]     IBW_RST     = 16'd256;

    typedef struct packed {
        logic              rd_en;
        logic [BIN_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BIN_AW-1:0] wr_addr;
        logic [BIN_W-1:0]  wr_data;
    } mem_cmd_t;

endpackage

// ===== src/rph_isqrt.sv =====
`timescale 1ns / 1ps

// Restoring integer square root, one result bit per cycle.
module rph_isqrt import rph_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [LIM_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic [LIM_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg, rad_reg[LIM_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ROOT_CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= REM_W'(rem_sh);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/rph_bin_mem.sv =====
`timescale 1ns / 1ps

// Bin store: one write and one registered read per cycle.
// Per-entry valid bits make every entry read as zero after reset.
module rph_bin_mem import rph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mem_cmd_t         cmd,
    output logic [BIN_W-1:0] rd_data
);

    logic [BIN_W-1:0]    bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0] valid_reg;
    logic                rvalid_reg;
    logic [BIN_W-1:0]    rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            bin_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= bin_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                valid_reg[cmd.wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rvalid_reg <= valid_reg[cmd.rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== src/radial_profile_histogram_top.sv =====
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid / in_ready     operation, grid_x/y/z, sample_re/im, bin_select
// out      out_valid / out_ready   bin_number, bin_value
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One request at a time. A read request reads its bin, then waits as needed for the
// output register. An accumulate runs the multiply stages, the bit-serial
// square root and the bin read-modify-write. A point outside the radius
// leaves after the radius test.
// rst_n clears the bins at once through per-bin valid bits; no clearing pass.
// A stalled result sits in the output register; the next request is taken
// meanwhile and only a read waits, at its last step, for the register.
module radial_profile_histogram_top import rph_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic        [GRID_W-1:0]    grid_x,
    input  logic        [GRID_W-1:0]    grid_y,
    input  logic        [GRID_W-1:0]    grid_z,
    input  logic signed [SAMPLE_W-1:0]  sample_re,
    input  logic signed [SAMPLE_W-1:0]  sample_im,
    input  logic        [SEL_W-1:0]     bin_select,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic        [SEL_W-1:0]     bin_number,
    output logic        [BIN_W-1:0]     bin_value,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_IDX_W-1:0] cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;   // waiting for a request
    localparam logic [3:0] S_MUL  = 4'd1;   // grid*spacing, sample squares, volume part, radius squared
    localparam logic [3:0] S_ABS  = 4'd2;   // |pos - centre|, density, full volume
    localparam logic [3:0] S_SQ   = 4'd3;   // per-axis squares, mass partial products
    localparam logic [3:0] S_SUM  = 4'd4;   // squared distance, mass
    localparam logic [3:0] S_CHK  = 4'd5;   // radius test, launch square root
    localparam logic [3:0] S_ROOT = 4'd6;   // square root running
    localparam logic [3:0] S_IDX  = 4'd7;   // r * inverse bin width
    localparam logic [3:0] S_RDA  = 4'd8;   // round, clamp, read bin
    localparam logic [3:0] S_ACC  = 4'd9;   // saturating add, write back
    localparam logic [3:0] S_RDS  = 4'd10;  // read request: read bin
    localparam logic [3:0] S_OUT  = 4'd11;  // deliver result, clear bin

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // configuration
    logic [COORD_W-1:0]   centre_reg  [AXES];
    logic [SPACING_W-1:0] spacing_reg [AXES];
    logic [COORD_W-1:0]   radius_reg;
    logic [IBW_W-1:0]     ibw_reg;

    // captured request
    logic [GRID_W-1:0]          grid_reg [AXES];
    logic signed [SAMPLE_W-1:0] re_reg;
    logic signed [SAMPLE_W-1:0] im_reg;
    logic [SEL_W-1:0]           sel_reg;

    // arithmetic pipeline
    logic [POS_W-1:0]  pos_reg  [AXES];
    logic [POS_W-1:0]  abs_reg  [AXES];
    logic [AXSQ_W-1:0] axsq_reg [AXES];
    logic [SQ_W-1:0]   re_sq_reg;
    logic [SQ_W-1:0]   im_sq_reg;
    logic [SQ_W-1:0]   den_reg;
    logic [VOL2_W-1:0] vol2_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic [PART_W-1:0] ph_reg;
    logic [PART_W-1:0] pl_reg;
    logic [D2_W-1:0]   d2_reg;
    logic [BIN_W-1:0]  mass_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [BIN_AW-1:0] addr_reg;

    // output register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SEL_W-1:0] bin_number_reg;
    logic [BIN_W-1:0] bin_value_reg;

    logic signed [SQ_W-1:0] re_sq;
    logic signed [SQ_W-1:0] im_sq;
    logic [PART_W:0]        mass_sum;
    logic [PROD_W:0]        rnd;
    logic [IDX_W-1:0]       idx;
    logic [BIN_AW-1:0]      acc_addr;
    logic [BIN_W:0]         acc_wide;
    logic [BIN_W-1:0]       acc_sum;
    logic                   grid_ok;
    logic                   sel_ok;
    logic                   in_fire;
    logic                   out_load;
    logic                   sq_start;
    logic                   sq_done;
    logic [ROOT_W-1:0]      sq_root;
    logic [BIN_W-1:0]       mem_rdata;
    mem_cmd_t               mem_cmd;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign grid_ok = (32'(grid_x) < GRID_SIZE) && (32'(grid_y) < GRID_SIZE) &&
                     (32'(grid_z) < GRID_SIZE);
    // reads beyond the store return zero and touch nothing
    assign sel_ok  = (32'(sel_reg) < NUM_BINS);

    // sample squares are non-negative, so the low bits are the magnitude
    assign re_sq = SQ_W'(re_reg) * SQ_W'(re_reg);
    assign im_sq = SQ_W'(im_reg) * SQ_W'(im_reg);

    // mass = floor(density * volume / 2^36), volume split in halves
    assign mass_sum = (PART_W + 1)'(ph_reg) + (PART_W + 1)'(pl_reg >> VOL_HALF);

    // bin number rounded half up, clamped to 1..NUM_BINS, stored at number - 1
    assign rnd = (PROD_W + 1)'(prod_reg) + ROUND_HALF;
    assign idx = rnd[PROD_W:ROUND_SH];

    always_comb
    begin
        if (idx == '0)
        begin
            acc_addr = '0;
        end
        else if (idx > IDX_W'(NUM_BINS))
        begin
            acc_addr = BIN_AW'(NUM_BINS - 1);
        end
        else
        begin
            acc_addr = BIN_AW'(idx - IDX_W'(1));
        end
    end

    // bins stick at full scale
    assign acc_wide = (BIN_W + 1)'(mem_rdata) + (BIN_W + 1)'(mass_reg);
    assign acc_sum  = acc_wide[BIN_W] ? '1 : acc_wide[BIN_W-1:0];

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                centre_reg[i]  <= '0;
                spacing_reg[i] <= SPACING_RST;
            end
            radius_reg <= RADIUS_RST;
            ibw_reg    <= IBW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTRE_X:  centre_reg[0]  <= cfg_data;
                REG_CENTRE_Y:  centre_reg[1]  <= cfg_data;
                REG_CENTRE_Z:  centre_reg[2]  <= cfg_data;
                REG_SPACING_X: spacing_reg[0] <= cfg_data[SPACING_W-1:0];
                REG_SPACING_Y: spacing_reg[1] <= cfg_data[SPACING_W-1:0];
                REG_SPACING_Z: spacing_reg[2] <= cfg_data[SPACING_W-1:0];
                REG_RADIUS:    radius_reg     <= cfg_data;
                REG_INV_WIDTH: ibw_reg        <= cfg_data[IBW_W-1:0];
                default:       ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sq_start   = 1'b0;
        out_load   = 1'b0;
        mem_cmd    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_READ)
                    begin
                        state_next = S_RDS;
                    end
                    else if (grid_ok)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: state_next = S_ABS;
            S_ABS: state_next = S_SQ;
            S_SQ:  state_next = S_SUM;
            S_SUM: state_next = S_CHK;
            S_CHK:
            begin
                // exact r < limit test on squares
                if (d2_reg < D2_W'(lim_reg))
                begin
                    sq_start   = 1'b1;
                    state_next = S_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = S_IDX;
                end
            end
            S_IDX: state_next = S_RDA;
            S_RDA:
            begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = acc_addr;
                state_next      = S_ACC;
            end
            S_ACC:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = addr_reg;
                mem_cmd.wr_data = acc_sum;
                state_next      = S_IDLE;
            end
            S_RDS:
            begin
                mem_cmd.rd_en   = sel_ok;
                mem_cmd.rd_addr = BIN_AW'(sel_reg);
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                // read data holds while the output register is still full
                if (!out_valid_reg || out_ready)
                begin
                    out_load        = 1'b1;
                    mem_cmd.wr_en   = sel_ok;
                    mem_cmd.wr_addr = BIN_AW'(sel_reg);
                    mem_cmd.wr_data = '0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            grid_reg[0] <= grid_x;
            grid_reg[1] <= grid_y;
            grid_reg[2] <= grid_z;
            re_reg      <= sample_re;
            im_reg      <= sample_im;
            sel_reg     <= bin_select;
        end

        if (state_reg == S_MUL)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                pos_reg[i] <= POS_W'(grid_reg[i]) * POS_W'(spacing_reg[i]);
            end
            re_sq_reg <= unsigned'(re_sq);
            im_sq_reg <= unsigned'(im_sq);
            vol2_reg  <= VOL2_W'(spacing_reg[0]) * VOL2_W'(spacing_reg[1]);
            lim_reg   <= LIM_W'(radius_reg) * LIM_W'(radius_reg);
        end

        if (state_reg == S_ABS)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                if (pos_reg[i] >= POS_W'(centre_reg[i]))
                begin
                    abs_reg[i] <= pos_reg[i] - POS_W'(centre_reg[i]);
                end
                else
                begin
                    abs_reg[i] <= POS_W'(centre_reg[i]) - pos_reg[i];
                end
            end
            den_reg <= re_sq_reg + im_sq_reg;
            vol_reg <= VOL_W'(vol2_reg) * VOL_W'(spacing_reg[2]);
        end

        if (state_reg == S_SQ)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                axsq_reg[i] <= AXSQ_W'(abs_reg[i]) * AXSQ_W'(abs_reg[i]);
            end
            ph_reg <= PART_W'(den_reg) * PART_W'(vol_reg[VOL_W-1:VOL_HALF]);
            pl_reg <= PART_W'(den_reg) * PART_W'(vol_reg[VOL_HALF-1:0]);
        end

        if (state_reg == S_SUM)
        begin
            d2_reg   <= D2_W'(axsq_reg[0]) + D2_W'(axsq_reg[1]) + D2_W'(axsq_reg[2]);
            mass_reg <= BIN_W'(mass_sum >> MASS_SH);
        end

        if (state_reg == S_IDX)
        begin
            prod_reg <= PROD_W'(sq_root) * PROD_W'(ibw_reg);
        end

        if (state_reg == S_RDA)
        begin
            addr_reg <= acc_addr;
        end

        if (out_load)
        begin
            bin_number_reg <= sel_reg;
            bin_value_reg  <= sel_ok ? mem_rdata : '0;
        end
    end

    // counted points have d2 below limit^2, so the low bits hold all of it
    rph_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (d2_reg[LIM_W-1:0]),
        .done     (sq_done),
        .root     (sq_root)
    );

    rph_bin_mem u_bins (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (mem_cmd),
        .rd_data (mem_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign bin_number = bin_number_reg;
    assign bin_value  = bin_value_reg;

endmodule

// ===== src/rph_checker.sv =====
`timescale 1ns / 1ps

`include "radial_profile_histogram_top_assert.svh"

module rph_checker import rph_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SEL_W-1:0] bin_number,
    input logic [BIN_W-1:0] bin_value
);

    // stalled result holds
    `RPH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bin_number) && $stable(bin_value))

    // one request at a time
    `RPH_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)

    // a new result only comes out of work in progress
    `RPH_ASSERT_IMP(a_result_from_work, $rose(out_valid), !$past(in_ready))

    // reads beyond the store return zero
    `RPH_ASSERT_IMP(a_oob_zero, out_valid && (32'(bin_number) >= NUM_BINS), bin_value == '0)

endmodule

bind radial_profile_histogram_top rph_checker u_rph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bin_number (bin_number),
    .bin_value  (bin_value)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for radial_profile_histogram_top.
//
// A request either accumulates one grid sample into the radial profile or
// reads and clears one bin. The bench keeps its own copy of the registers
// and of the bin store. It predicts every read result when the request is
// accepted, and compares each result the block returns against the oldest
// prediction.
//
// Register writes only happen while the block is idle. An accumulate never
// returns a result, so an empty prediction queue does not prove the block is
// idle. settle() therefore waits out a pipeline drain on top of the queue.
module testbench;
    import rph_pkg::*;

    // Run shape
    localparam int CYCLE_LIMIT     = 250000;   // several times the slowest clean run
    localparam int PIPE_DRAIN      = 64;       // covers the deepest accumulate
    localparam int RANDOM_PHASES   = 10;
    localparam int QUIET_PHASES    = 2;        // last phases run with no idling
    localparam int ITEMS_PER_PHASE = 30;
    localparam int SATURATION_HITS = 36;       // about 2^43 each at full volume
    localparam int MAX_REPORTS     = 200;

    localparam longint unsigned BIN_MAX   = (64'd1 << BIN_W) - 1;
    localparam longint unsigned COORD_MAX = (64'd1 << COORD_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_INV_WIDTH + 1'b1;

    // One input request and one read result, at the block's widths
    typedef struct {
        logic                       op;
        logic        [GRID_W-1:0]   gx;
        logic        [GRID_W-1:0]   gy;
        logic        [GRID_W-1:0]   gz;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic        [SEL_W-1:0]    sel;
    } profile_req_t;

    typedef struct {
        logic [SEL_W-1:0] number;
        logic [BIN_W-1:0] value;
    } bin_read_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        operation;
    logic        [GRID_W-1:0]    grid_x;
    logic        [GRID_W-1:0]    grid_y;
    logic        [GRID_W-1:0]    grid_z;
    logic signed [SAMPLE_W-1:0]  sample_re;
    logic signed [SAMPLE_W-1:0]  sample_im;
    logic        [SEL_W-1:0]     bin_select;
    logic                        out_valid;
    logic                        out_ready;
    logic        [SEL_W-1:0]     bin_number;
    logic        [BIN_W-1:0]     bin_value;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [CFG_DATA_W-1:0] cfg_data;

    // Predicted register file and bin store
    logic [COORD_W-1:0]   prof_centre_x;
    logic [COORD_W-1:0]   prof_centre_y;
    logic [COORD_W-1:0]   prof_centre_z;
    logic [SPACING_W-1:0] prof_spacing_x;
    logic [SPACING_W-1:0] prof_spacing_y;
    logic [SPACING_W-1:0] prof_spacing_z;
    logic [COORD_W-1:0]   prof_radius;
    logic [IBW_W-1:0]     prof_inv_width;
    logic [BIN_W-1:0]     bin_mass [NUM_BINS];

    bin_read_t expected_reads [$];

    bit quiet      = 1'b0;   // no idling on either side
    bit block_busy = 1'b0;   // requests sent since the last settle()
    int mismatches      = 0;
    int results_checked = 0;
    int reads_sent      = 0;
    int accums_sent     = 0;
    int settings_loaded = 0;
    int cycle_count     = 0;

    radial_profile_histogram_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .grid_x     (grid_x),
        .grid_y     (grid_y),
        .grid_z     (grid_z),
        .sample_re  (sample_re),
        .sample_im  (sample_im),
        .bin_select (bin_select),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bin_number (bin_number),
        .bin_value  (bin_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Profile predictor
    // ------------------------------------------------------------------

    // Squared offset of one axis from the centre, Q.24, exact.
    function automatic longint unsigned offset_sq(input logic [GRID_W-1:0] g,
                                                  input logic [SPACING_W-1:0] sp,
                                                  input logic [COORD_W-1:0] c);
        longint unsigned pos;
        longint unsigned span;
        pos  = 64'(g) * 64'(sp);
        span = (pos >= 64'(c)) ? pos - 64'(c) : 64'(c) - pos;
        return span * span;
    endfunction

    // Integer square root, rounded down (digit-by-digit).
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        longint unsigned rem;
        acc   = 0;
        rem   = v;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rem >= acc + probe)
            begin
                rem -= acc + probe;
                acc = (acc >> 1) + probe;
            end
            else
                acc >>= 1;
            probe >>= 2;
        end
        return acc;
    endfunction

    // Adds one grid sample to the predicted store.
    function automatic void deposit_sample(input profile_req_t req);
        longint unsigned d2;
        longint unsigned lim;
        longint unsigned root;
        longint unsigned slot;
        longint unsigned den;
        longint unsigned vol;
        longint unsigned mass;
        longint unsigned total;
        longint sre;
        longint sim;
        if (req.gx >= GRID_SIZE || req.gy >= GRID_SIZE || req.gz >= GRID_SIZE)
            return;
        d2 = offset_sq(req.gx, prof_spacing_x, prof_centre_x)
           + offset_sq(req.gy, prof_spacing_y, prof_centre_y)
           + offset_sq(req.gz, prof_spacing_z, prof_centre_z);
        lim = 64'(prof_radius) * 64'(prof_radius);
        if (d2 >= lim)
            return;
        root = floor_root(d2);
        // round half up, then clamp to 1..NUM_BINS
        slot = (root * 64'(prof_inv_width) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
        if (slot < 1)
            slot = 1;
        if (slot > NUM_BINS)
            slot = NUM_BINS;
        sre  = req.re;
        sim  = req.im;
        den  = sre * sre + sim * sim;
        vol  = 64'(prof_spacing_x) * 64'(prof_spacing_y) * 64'(prof_spacing_z);
        // density * volume / 2^36, split so nothing overflows 64 bits
        mass = (den * (vol >> 24) + ((den * (vol & 64'hFF_FFFF)) >> 24)) >> MASS_SH;
        total = 64'(bin_mass[slot - 1]) + mass;
        if (total > BIN_MAX)
            total = BIN_MAX;
        bin_mass[slot - 1] = total[BIN_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------

    // Fields a request does not use carry random junk.
    function automatic profile_req_t accum_req(input logic [GRID_W-1:0] gx,
                                               input logic [GRID_W-1:0] gy,
                                               input logic [GRID_W-1:0] gz,
                                               input logic signed [SAMPLE_W-1:0] re,
                                               input logic signed [SAMPLE_W-1:0] im);
        profile_req_t req;
        req.op  = OP_ACCUM;
        req.gx  = gx;
        req.gy  = gy;
        req.gz  = gz;
        req.re  = re;
        req.im  = im;
        req.sel = SEL_W'($urandom);
        return req;
    endfunction

    function automatic profile_req_t read_req(input logic [SEL_W-1:0] sel);
        profile_req_t req;
        req.op  = OP_READ;
        req.gx  = GRID_W'($urandom);
        req.gy  = GRID_W'($urandom);
        req.gz  = GRID_W'($urandom);
        req.re  = SAMPLE_W'($urandom);
        req.im  = SAMPLE_W'($urandom);
        req.sel = sel;
        return req;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] full_scale();
        return ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
    endfunction

    // Grid index within a dozen cells of the centre, so most points count.
    function automatic logic [GRID_W-1:0] grid_near(input logic [COORD_W-1:0] c,
                                                    input logic [SPACING_W-1:0] sp);
        int base;
        if (sp == 0)
            return GRID_W'($urandom_range(0, GRID_SIZE - 1));
        base = int'(c / sp) + int'($urandom_range(0, 24)) - 12;
        if (base < 0)
            base = 0;
        if (base > GRID_SIZE - 1)
            base = GRID_SIZE - 1;
        return GRID_W'(base);
    endfunction

    // A bin that holds mass, if any; otherwise a random one.
    function automatic logic [SEL_W-1:0] loaded_bin();
        int start;
        int i;
        start = $urandom_range(0, NUM_BINS - 1);
        for (i = 0; i < NUM_BINS; i++)
            if (bin_mass[(start + i) % NUM_BINS] != 0)
                return SEL_W'((start + i) % NUM_BINS);
        return SEL_W'(start);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one request; predicts its effect at the accepting edge.
    task automatic send_req(input profile_req_t req);
        int gap;
        bin_read_t hit;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        operation  = req.op;
        grid_x     = req.gx;
        grid_y     = req.gy;
        grid_z     = req.gz;
        sample_re  = req.re;
        sample_im  = req.im;
        bin_select = req.sel;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        block_busy = 1'b1;
        if (req.op == OP_READ)
        begin
            hit.number = req.sel;
            hit.value  = '0;
            if (req.sel < NUM_BINS)
            begin
                hit.value = bin_mass[req.sel];
                bin_mass[req.sel] = '0;
            end
            expected_reads.push_back(hit);
            reads_sent++;
        end
        else
        begin
            deposit_sample(req);
            accums_sent++;
        end
    endtask

    // Drop valid, wait for every read result, then let accumulates drain.
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
        block_busy = 1'b0;
    endtask

    // Register write; only issued with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        if (block_busy)
            settle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            REG_CENTRE_X:  prof_centre_x  = data[COORD_W-1:0];
            REG_CENTRE_Y:  prof_centre_y  = data[COORD_W-1:0];
            REG_CENTRE_Z:  prof_centre_z  = data[COORD_W-1:0];
            REG_SPACING_X: prof_spacing_x = data[SPACING_W-1:0];
            REG_SPACING_Y: prof_spacing_y = data[SPACING_W-1:0];
            REG_SPACING_Z: prof_spacing_z = data[SPACING_W-1:0];
            REG_RADIUS:    prof_radius    = data[COORD_W-1:0];
            REG_INV_WIDTH: prof_inv_width = data[IBW_W-1:0];
            default: ;     // unused index: no effect
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random ready bursts, always ready once quiet.
    initial
    begin : ready_driver
        int burst;
        bit stall;
        burst     = 0;
        stall     = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_ready = 1'b1;
            else
            begin
                if (burst == 0)
                begin
                    stall = ($urandom_range(0, 2) == 0);
                    burst = stall ? $urandom_range(1, 6) : $urandom_range(1, 8);
                end
                out_ready = !stall;
                burst--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    endtask

    task automatic check_bin_result(input logic [SEL_W-1:0] num,
                                    input logic [BIN_W-1:0] val);
        bin_read_t want;
        if (expected_reads.size() == 0)
        begin
            note_mismatch("unrequested result, bin_number", 0, num);
            return;
        end
        want = expected_reads.pop_front();
        results_checked++;
        if (num !== want.number)
            note_mismatch("bin_number", want.number, num);
        if (val !== want.value)
            note_mismatch($sformatf("bin_value of bin %0d", want.number), want.value, val);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            check_bin_result(bin_number, bin_value);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: empty store, unit spacing, centre at origin, 1 bin/unit.
    // Covers the clamp at both ends of the bin range and read-clear.
    task automatic test_reset_state();
        send_req(read_req(0));
        send_req(read_req(SEL_W'(NUM_BINS - 1)));
        send_req(accum_req(0, 0, 0, 16'sh8000, 16'sh8000));        // r = 0 -> bin 1
        send_req(accum_req(1023, 1023, 1023, 16'sh7FFF, 16'sh8000)); // clamps to top
        send_req(accum_req(1, 0, 0, 16'sh0000, 16'sh0000));        // zero mass
        send_req(accum_req(0, 2, 0, 16'sd123, -16'sd456));
        send_req(read_req(0));
        send_req(read_req(1));
        send_req(read_req(SEL_W'(NUM_BINS - 1)));
        send_req(read_req(0));                                      // cleared
    endtask

    // r * inverse width lands exactly halfway between bins: rounds up.
    task automatic test_rounding_tie();
        write_reg(REG_CENTRE_X, 24'd2048);                          // half a unit
        send_req(accum_req(3, 0, 0, 16'sd1000, 16'sd1000));        // r = 2.5
        send_req(accum_req(2, 0, 0, 16'sh4000, 16'sh0000));        // r = 1.5
        send_req(read_req(1));
        send_req(read_req(2));
        write_reg(REG_CENTRE_X, 24'd0);
    endtask

    // Distance equal to the limit is dropped; just inside counts; zero limit
    // drops everything.
    task automatic test_radius_edge();
        write_reg(REG_RADIUS, 24'd12288);                           // 3.0 units
        send_req(accum_req(3, 0, 0, 16'sh7FFF, 16'sh7FFF));
        send_req(accum_req(0, 0, 3, 16'sh7FFF, 16'sh7FFF));
        send_req(accum_req(2, 2, 0, 16'sd2000, -16'sd3000));       // r = 2.83
        write_reg(REG_RADIUS, 24'd0);
        send_req(accum_req(0, 0, 0, 16'sh7FFF, 16'sh7FFF));
        send_req(read_req(2));
        send_req(read_req(0));
        write_reg(REG_RADIUS, RADIUS_RST);
    endtask

    // Zero inverse width sends every point to bin 1; full width saturates high.
    task automatic test_width_extremes();
        write_reg(REG_INV_WIDTH, 24'h000000);
        send_req(accum_req(1023, 0, 0, -16'sd5000, 16'sd7000));
        write_reg(REG_INV_WIDTH, 24'hFFFFFF);
        send_req(accum_req(1, 0, 0, 16'sd9000, 16'sd11));
        send_req(read_req(0));
        send_req(read_req(SEL_W'(NUM_BINS - 1)));
        write_reg(REG_INV_WIDTH, {8'h00, IBW_RST});
    endtask

    // Writes to unused indexes must not disturb the live registers.
    task automatic test_unused_registers();
        int i;
        for (i = REG_FIRST_UNUSED; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        send_req(accum_req(0, 0, 1, pick_sample(), pick_sample()));
        send_req(read_req(0));
    endtask

    // Full-scale volume and samples pile into bin 1 until it sticks at max.
    task automatic test_bin_saturation();
        int i;
        write_reg(REG_SPACING_X, 24'hFFFFFF);
        write_reg(REG_SPACING_Y, 24'hFFFFFF);
        write_reg(REG_SPACING_Z, 24'hFFFFFF);
        for (i = 0; i < SATURATION_HITS; i++)
            send_req(accum_req(0, 0, 0, full_scale(), full_scale()));
        send_req(read_req(0));
        send_req(accum_req(0, 0, 0, full_scale(), full_scale()));
        send_req(read_req(0));
    endtask

    // Loads one register setting. Phases 0 and 1 are fixed corners, phase 2 zeroes the X spacing, then random.
    task automatic random_setting(input int phase);
        logic [COORD_W-1:0]    c [3];
        logic [SPACING_W-1:0]  s [3];
        logic [COORD_W-1:0]    rl;
        logic [IBW_W-1:0]      w;
        logic [CFG_DATA_W-1:0] noise;
        longint unsigned       aligned;
        int a;
        for (a = 0; a < AXES; a++)
        begin
            s[a] = ($urandom_range(0, 3) == 0) ? SPACING_W'($urandom)
                                               : SPACING_W'($urandom_range(1024, 16384));
            if (s[a] != 0 && $urandom_range(0, 2) != 0)
            begin
                // centre close to a grid point so nearby points fall inside
                aligned = 64'($urandom_range(0, GRID_SIZE - 1)) * 64'(s[a])
                        + 64'($urandom_range(0, s[a]));
                c[a] = (aligned > COORD_MAX) ? COORD_W'(COORD_MAX) : COORD_W'(aligned);
            end
            else
                c[a] = COORD_W'($urandom);
        end
        rl = ($urandom_range(0, 3) == 0) ? '1 : COORD_W'($urandom_range(4096, 200 * 4096));
        case ($urandom_range(0, 5))
            0: w = '0;
            1: w = '1;
            default: w = IBW_W'($urandom_range(64, 4096));
        endcase
        case (phase)
            0:
            begin
                c  = '{'1, '1, '1};
                s  = '{'1, '1, '1};
                rl = '1;
                w  = '1;
            end
            1:
            begin
                c  = '{'0, '0, '0};
                s  = '{1, 1, 1};
                rl = '1;
                w  = '1;
            end
            2: s[0] = '0;
            default: ;
        endcase
        noise = CFG_DATA_W'($urandom);
        write_reg(REG_CENTRE_X, c[0]);
        write_reg(REG_CENTRE_Y, c[1]);
        write_reg(REG_CENTRE_Z, c[2]);
        write_reg(REG_SPACING_X, {noise[CFG_DATA_W-1:SPACING_W], s[0]});
        write_reg(REG_SPACING_Y, {noise[CFG_DATA_W-1:SPACING_W], s[1]});
        write_reg(REG_SPACING_Z, {noise[CFG_DATA_W-1:SPACING_W], s[2]});
        write_reg(REG_RADIUS, rl);
        write_reg(REG_INV_WIDTH, {noise[CFG_DATA_W-1:IBW_W], w});
        settings_loaded++;
    endtask

    // Mostly points near the centre, some anywhere on the grid, and reads
    // that favor bins known to hold mass.
    task automatic test_random_profiles();
        int phase;
        int n;
        logic [SEL_W-1:0] sel;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_setting(phase);
            if (phase >= RANDOM_PHASES - QUIET_PHASES)
                quiet = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    if ($urandom_range(0, 1) != 0)
                        sel = loaded_bin();
                    else
                        sel = SEL_W'($urandom_range(0, NUM_BINS - 1));
                    send_req(read_req(sel));
                end
                else if ($urandom_range(0, 4) == 0)
                    send_req(accum_req(GRID_W'($urandom), GRID_W'($urandom),
                                       GRID_W'($urandom),
                                       pick_sample(), pick_sample()));
                else
                    send_req(accum_req(grid_near(prof_centre_x, prof_spacing_x),
                                       grid_near(prof_centre_y, prof_spacing_y),
                                       grid_near(prof_centre_z, prof_spacing_z),
                                       pick_sample(), pick_sample()));
            end
        end
    endtask

    // Read back every bin still holding mass, back to back.
    task automatic test_final_sweep();
        int i;
        settle();
        for (i = 0; i < NUM_BINS; i++)
            if (bin_mass[i] != 0)
                send_req(read_req(SEL_W'(i)));
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : main_sequence
        int i;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_ACCUM;
        grid_x     = '0;
        grid_y     = '0;
        grid_z     = '0;
        sample_re  = '0;
        sample_im  = '0;
        bin_select = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_CENTRE_X;
        cfg_data   = '0;

        prof_centre_x  = '0;
        prof_centre_y  = '0;
        prof_centre_z  = '0;
        prof_spacing_x = SPACING_RST;
        prof_spacing_y = SPACING_RST;
        prof_spacing_z = SPACING_RST;
        prof_radius    = RADIUS_RST;
        prof_inv_width = IBW_RST;
        for (i = 0; i < NUM_BINS; i++)
            bin_mass[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_rounding_tie();
        test_radius_edge();
        test_width_extremes();
        test_unused_registers();
        test_bin_saturation();
        test_random_profiles();
        test_final_sweep();
        settle();

        $display("Covered %0d accumulate and %0d read requests over %0d random settings",
                 accums_sent, reads_sent, settings_loaded);
        $display("plus rounding ties, radius edge, width extremes, saturation; %0d reads compared",
                 results_checked);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles, %0d reads outstanding",
                 cycle_count, expected_reads.size());
        $display("FAILURE");
        $finish;
    end

endmodule
